[src/plcm_pkg.sv]
// ============================================================================
// plcm_pkg
// Shared constants for the piecewise-linear color map core: register
// indexes, field widths and the reset values of the ramp stops.
// ============================================================================
package plcm_pkg;

    // Default sizes of the ramp and of one sample.
    localparam int MAX_STOPS_DEF  = 7;
    localparam int VALUE_BITS_DEF = 24;

    // One color channel and the packed RGBA word of a stop.
    localparam int COLOR_BITS      = 8;
    localparam int CHANNELS        = 4;
    localparam int STOP_COLOR_BITS = CHANNELS * COLOR_BITS;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam int REG_STOP_COUNT = 0;
    localparam int REG_STOP_FIRST = 1;

    // Stop count register.
    localparam int STOP_COUNT_BITS  = 3;
    localparam int STOP_COUNT_MIN   = 2;
    localparam int STOP_COUNT_RESET = 2;

    // Reset ramp: black to red, both opaque, over positions 0 to 255.
    localparam logic [STOP_COLOR_BITS-1:0] STOP0_COLOR_RESET = 32'h0000_00FF;
    localparam logic [STOP_COLOR_BITS-1:0] STOP1_COLOR_RESET = 32'hFF00_00FF;
    localparam int                         STOP1_POS_RESET   = 255;

endpackage

[src/piecewise_linear_color_map_core.sv]
// ============================================================================
// piecewise_linear_color_map_core
// Maps a signed sample to an RGBA color by linear interpolation between the
// two ramp stops that enclose it, with a pipelined restoring divider.
// ============================================================================
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------
//  input    | in_valid/in_ready  | sample
//  output   | out_valid/out_ready| red, green, blue, opacity
//  config   | cfg_we             | cfg_index, cfg_data
//
// One transaction is taken every cycle unless the output stalls. The stages
// are compare, stop select, operand fetch, multiply, one stage per quotient
// bit of the 8-bit divider, and the output register; the divider sets the
// pipeline depth. Each stage has its own valid bit and takes new data
// whenever it is empty or the stage after it moves, so bubbles close up
// during a stall and no transaction is lost or repeated. Reset clears the
// valid bits and loads the reset ramp into the stop registers.
module piecewise_linear_color_map_core
    import plcm_pkg::*;
#(
    parameter int MAX_STOPS  = MAX_STOPS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]            cfg_index,
    input  logic [STOP_COLOR_BITS+VALUE_BITS-1:0] cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [VALUE_BITS-1:0]         sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [COLOR_BITS-1:0]                red,
    output logic [COLOR_BITS-1:0]                green,
    output logic [COLOR_BITS-1:0]                blue,
    output logic [COLOR_BITS-1:0]                opacity
);

    localparam int IDXW      = $clog2(MAX_STOPS);
    localparam int STOP_BITS = STOP_COLOR_BITS + VALUE_BITS;
    localparam int PROD_BITS = VALUE_BITS + COLOR_BITS;
    localparam int DIV_STEPS = COLOR_BITS;

    localparam int ST_CMP = 0;
    localparam int ST_SEL = 1;
    localparam int ST_OPR = 2;
    localparam int ST_MUL = 3;
    localparam int ST_OUT = ST_MUL + DIV_STEPS + 1;
    localparam int NSTG   = ST_OUT + 1;

    typedef struct packed {
        logic                                 interp;
        logic [CHANNELS-1:0]                  neg;
        logic [CHANNELS-1:0][COLOR_BITS-1:0]  base;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [STOP_COUNT_BITS-1:0] stop_count_reg;
    logic [STOP_BITS-1:0]       stop_reg [MAX_STOPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= STOP_COUNT_BITS'(STOP_COUNT_RESET);
            for (int k = 0; k < MAX_STOPS; k++)
            begin
                if (k == 0)
                    stop_reg[k] <= {VALUE_BITS'(0), STOP0_COLOR_RESET};
                else if (k == 1)
                    stop_reg[k] <= {VALUE_BITS'(STOP1_POS_RESET), STOP1_COLOR_RESET};
                else
                    stop_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_INDEX_BITS'(REG_STOP_COUNT))
                stop_count_reg <= cfg_data[STOP_COUNT_BITS-1:0];
            for (int k = 0; k < MAX_STOPS; k++)
            begin
                if (cfg_index == CFG_INDEX_BITS'(REG_STOP_FIRST + k))
                    stop_reg[k] <= cfg_data;
            end
        end
    end

    logic signed [VALUE_BITS-1:0] pos [MAX_STOPS];
    logic [CHANNELS-1:0][COLOR_BITS-1:0] col [MAX_STOPS];
    logic [IDXW-1:0] last_idx;

    always_comb
    begin
        for (int k = 0; k < MAX_STOPS; k++)
        begin
            pos[k] = stop_reg[k][STOP_BITS-1:STOP_COLOR_BITS];
            for (int ch = 0; ch < CHANNELS; ch++)
                col[k][ch] = stop_reg[k][STOP_COLOR_BITS-1-COLOR_BITS*ch -: COLOR_BITS];
        end
        if (stop_count_reg < STOP_COUNT_BITS'(STOP_COUNT_MIN))
            last_idx = IDXW'(STOP_COUNT_MIN - 1);
        else if (int'(stop_count_reg) > MAX_STOPS)
            last_idx = IDXW'(MAX_STOPS - 1);
        else
            last_idx = IDXW'(stop_count_reg - STOP_COUNT_BITS'(1));
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // loads.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    logic [NSTG-1:0] vld_in;

    always_comb
    begin
        rdy[NSTG] = out_ready;
        for (int s = NSTG - 1; s >= 0; s--)
            rdy[s] = !vld_reg[s] || rdy[s+1];
    end

    assign vld_in   = {vld_reg[NSTG-2:0], in_valid};
    assign in_ready = rdy[ST_CMP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                if (rdy[s])
                    vld_reg[s] <= vld_in[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Compare stage
    // ------------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] cmp_z_reg;
    logic                         cmp_ge_last_reg, cmp_ge_last_next;
    logic                         cmp_le_first_reg, cmp_le_first_next;
    logic [MAX_STOPS-2:0]         cmp_hit_reg, cmp_hit_next;

    always_comb
    begin
        cmp_ge_last_next  = sample >= pos[last_idx];
        cmp_le_first_next = sample <= pos[0];
        for (int j = 0; j < MAX_STOPS - 1; j++)
            cmp_hit_next[j] = pos[j+1] >= sample;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_CMP])
        begin
            cmp_z_reg        <= sample;
            cmp_ge_last_reg  <= cmp_ge_last_next;
            cmp_le_first_reg <= cmp_le_first_next;
            cmp_hit_reg      <= cmp_hit_next;
        end
    end

    // ------------------------------------------------------------------
    // Select stage: the last stop wins over the first, then the first
    // enclosing stop.
    // ------------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] sel_z_reg;
    logic [IDXW-1:0]              sel_lo_reg, sel_lo_next;
    logic [IDXW-1:0]              sel_hi_reg, sel_hi_next;
    logic                         sel_interp_reg, sel_interp_next;

    always_comb
    begin
        sel_hi_next = '0;
        for (int j = MAX_STOPS - 2; j >= 0; j--)
        begin
            if (cmp_hit_reg[j])
                sel_hi_next = IDXW'(j + 1);
        end
        sel_interp_next = 1'b0;
        if (cmp_ge_last_reg)
            sel_hi_next = last_idx;
        else if (cmp_le_first_reg)
            sel_hi_next = '0;
        else
            sel_interp_next = 1'b1;
        sel_lo_next = sel_interp_next ? sel_hi_next - IDXW'(1) : sel_hi_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SEL])
        begin
            sel_z_reg      <= cmp_z_reg;
            sel_lo_reg     <= sel_lo_next;
            sel_hi_reg     <= sel_hi_next;
            sel_interp_reg <= sel_interp_next;
        end
    end

    // ------------------------------------------------------------------
    // Operand stage: segment offsets and color differences.
    // ------------------------------------------------------------------
    logic [VALUE_BITS-1:0] opr_zd_reg, opr_zd_next;
    logic [VALUE_BITS-1:0] opr_d_reg, opr_d_next;
    logic [CHANNELS-1:0][COLOR_BITS-1:0] opr_mag_reg, opr_mag_next;
    side_t                 opr_side_reg, opr_side_next;

    always_comb
    begin
        logic signed [VALUE_BITS:0] zd_wide;
        logic signed [VALUE_BITS:0] d_wide;
        logic signed [COLOR_BITS:0] dc;
        zd_wide = {sel_z_reg[VALUE_BITS-1], sel_z_reg}
                - {pos[sel_lo_reg][VALUE_BITS-1], pos[sel_lo_reg]};
        d_wide  = {pos[sel_hi_reg][VALUE_BITS-1], pos[sel_hi_reg]}
                - {pos[sel_lo_reg][VALUE_BITS-1], pos[sel_lo_reg]};
        opr_zd_next = zd_wide[VALUE_BITS-1:0];
        opr_d_next  = d_wide[VALUE_BITS-1:0];
        opr_side_next.interp = sel_interp_reg;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            dc = $signed({1'b0, col[sel_hi_reg][ch]}) - $signed({1'b0, col[sel_lo_reg][ch]});
            opr_side_next.neg[ch]  = dc[COLOR_BITS];
            opr_side_next.base[ch] = col[sel_lo_reg][ch];
            opr_mag_next[ch] = dc[COLOR_BITS] ? COLOR_BITS'(-dc) : dc[COLOR_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OPR])
        begin
            opr_zd_reg   <= opr_zd_next;
            opr_d_reg    <= opr_d_next;
            opr_mag_reg  <= opr_mag_next;
            opr_side_reg <= opr_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage (entry 0) and one restoring divide step per stage.
    // The dividend stays below 256 times the divisor, so eight quotient
    // bits are exact.
    // ------------------------------------------------------------------
    logic [PROD_BITS-1:0]  rem_reg  [DIV_STEPS+1][CHANNELS];
    logic [PROD_BITS-1:0]  rem_next [DIV_STEPS+1][CHANNELS];
    logic [COLOR_BITS-1:0] quo_reg  [DIV_STEPS+1][CHANNELS];
    logic [COLOR_BITS-1:0] quo_next [DIV_STEPS+1][CHANNELS];
    logic [VALUE_BITS-1:0] div_d_reg [DIV_STEPS+1];
    side_t                 side_reg  [DIV_STEPS+1];

    always_comb
    begin
        logic [PROD_BITS-1:0] dsh;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            rem_next[0][ch] = PROD_BITS'(opr_zd_reg) * PROD_BITS'(opr_mag_reg[ch]);
            quo_next[0][ch] = '0;
        end
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            dsh = PROD_BITS'(div_d_reg[j-1]) << (DIV_STEPS - j);
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                rem_next[j][ch] = rem_reg[j-1][ch];
                quo_next[j][ch] = quo_reg[j-1][ch];
                if (rem_reg[j-1][ch] >= dsh)
                begin
                    rem_next[j][ch] = rem_reg[j-1][ch] - dsh;
                    quo_next[j][ch][DIV_STEPS-j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= DIV_STEPS; j++)
        begin
            if (rdy[ST_MUL+j])
            begin
                rem_reg[j] <= rem_next[j];
                quo_reg[j] <= quo_next[j];
                if (j == 0)
                begin
                    div_d_reg[j] <= opr_d_reg;
                    side_reg[j]  <= opr_side_reg;
                end
                else
                begin
                    div_d_reg[j] <= div_d_reg[j-1];
                    side_reg[j]  <= side_reg[j-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor correction for falling channels, add the base.
    // ------------------------------------------------------------------
    logic [CHANNELS-1:0][COLOR_BITS-1:0] out_reg, out_next;

    always_comb
    begin
        logic signed [COLOR_BITS+1:0] delta;
        logic signed [COLOR_BITS+1:0] sum;
        logic                         inexact;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            inexact = rem_reg[DIV_STEPS][ch] != '0;
            delta   = $signed({2'b00, quo_reg[DIV_STEPS][ch]});
            if (side_reg[DIV_STEPS].neg[ch])
                delta = -delta - $signed({{(COLOR_BITS+1){1'b0}}, inexact});
            sum = $signed({2'b00, side_reg[DIV_STEPS].base[ch]}) + delta;
            out_next[ch] = side_reg[DIV_STEPS].interp ? sum[COLOR_BITS-1:0]
                                                      : side_reg[DIV_STEPS].base[ch];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_OUT])
            out_reg <= out_next;
    end

    assign out_valid = vld_reg[ST_OUT];
    assign red       = out_reg[0];
    assign green     = out_reg[1];
    assign blue      = out_reg[2];
    assign opacity   = out_reg[3];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        last_idx != '0 && int'(last_idx) < MAX_STOPS)
        else $error("effective stop count out of range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[ST_CMP])
        else $error("accepted transaction did not enter the pipeline");

    a_segment_sane: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OPR] && opr_side_reg.interp |->
            opr_d_reg != '0 && opr_zd_reg != '0 && opr_zd_reg <= opr_d_reg)
        else $error("selected segment does not enclose the sample");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT-1] && side_reg[DIV_STEPS].interp |->
            rem_reg[DIV_STEPS][0] < PROD_BITS'(div_d_reg[DIV_STEPS]) &&
            rem_reg[DIV_STEPS][1] < PROD_BITS'(div_d_reg[DIV_STEPS]) &&
            rem_reg[DIV_STEPS][2] < PROD_BITS'(div_d_reg[DIV_STEPS]) &&
            rem_reg[DIV_STEPS][3] < PROD_BITS'(div_d_reg[DIV_STEPS]))
        else $error("divider remainder not below divisor");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_MUL] && !rdy[ST_MUL] |=> vld_reg[ST_MUL] && $stable(rem_reg[0][0]))
        else $error("stalled multiply stage lost its transaction");

endmodule
